### rtl/core/hwas_pkg.sv
// ----------------------------------------------------------------------------
// hwas_pkg
// Shared widths, request codes, sequencer states and the command bundle of
// the additive wavetable synthesizer.
// ----------------------------------------------------------------------------
package hwas_pkg;

  // Field widths of the request, result and configuration ports
  localparam int FUNC_W  = 2;
  localparam int TADDR_W = 10;
  localparam int SAMP_W  = 16;
  localparam int HNUM_W  = 3;
  localparam int GAIN_W  = 16;
  localparam int STEP_W  = 26;

  // Phase fraction bits and width of the biased average quotient
  localparam int FRAC_W  = 16;
  localparam int QUO_W   = 17;

  // Default sizes
  localparam int DEF_HARMONICS   = 8;
  localparam int DEF_TABLE_DEPTH = 1024;

  // Request codes
  localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TABLE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_GAIN   = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_GAIN,
    ST_ACC,
    ST_DIVI,
    ST_DIV,
    ST_OUT
  } state_t;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic wr_table;
    logic wr_gain;
    logic start;
    logic read;
    logic mul;
    logic gain;
    logic acc;
    logic div_init;
    logic div_step;
    logic load_out;
  } cmd_t;

endpackage

### rtl/core/hwas_ctrl.sv
// ----------------------------------------------------------------------------
// hwas_ctrl
// Sequencer: takes requests, steps the datapath through every harmonic and
// the averaging divider, and owns the result valid flag.
// ----------------------------------------------------------------------------
module hwas_ctrl #(
  parameter int HARMONICS = hwas_pkg::DEF_HARMONICS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [hwas_pkg::FUNC_W-1:0] in_func,
  output logic                        out_valid,
  input  logic                        out_stall,
  output hwas_pkg::cmd_t              cmd
);

  localparam int KW = (HARMONICS > 1) ? $clog2(HARMONICS) : 1;

  hwas_pkg::state_t state_r, state_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic             out_valid_r, out_valid_nxt;

  // State, counters and result flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hwas_pkg::ST_IDLE;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    in_stall      = 1'b1;
    unique case (state_r)
      hwas_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          unique case (in_func)
            hwas_pkg::FUNC_SAMPLE: begin
              cmd.start = 1'b1;
              k_nxt     = '0;
              state_nxt = hwas_pkg::ST_READ;
            end
            hwas_pkg::FUNC_TABLE: cmd.wr_table = 1'b1;
            hwas_pkg::FUNC_GAIN:  cmd.wr_gain  = 1'b1;
            default: ;
          endcase
        end
      end
      hwas_pkg::ST_READ: begin
        cmd.read  = 1'b1;
        state_nxt = hwas_pkg::ST_MUL;
      end
      hwas_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = hwas_pkg::ST_GAIN;
      end
      hwas_pkg::ST_GAIN: begin
        cmd.gain  = 1'b1;
        state_nxt = hwas_pkg::ST_ACC;
      end
      hwas_pkg::ST_ACC: begin
        // accumulate and rotate to the next harmonic
        cmd.acc = 1'b1;
        if (k_r == KW'(HARMONICS - 1)) begin
          state_nxt = hwas_pkg::ST_DIVI;
        end else begin
          k_nxt     = k_r + KW'(1);
          state_nxt = hwas_pkg::ST_READ;
        end
      end
      hwas_pkg::ST_DIVI: begin
        cmd.div_init = 1'b1;
        state_nxt    = hwas_pkg::ST_DIV;
      end
      hwas_pkg::ST_DIV: begin
        // scale by the reciprocal of the harmonic count
        cmd.div_step = 1'b1;
        state_nxt    = hwas_pkg::ST_OUT;
      end
      hwas_pkg::ST_OUT: begin
        // hold until the result register is free
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = hwas_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hwas_pkg::ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/core/hwas_dp.sv
// ----------------------------------------------------------------------------
// hwas_dp
// Datapath: wave table memory, rotating phase and gain rings, interpolation
// and gain multipliers, accumulator, reciprocal divider and result register.
// ----------------------------------------------------------------------------
module hwas_dp #(
  parameter int HARMONICS   = hwas_pkg::DEF_HARMONICS,
  parameter int TABLE_DEPTH = hwas_pkg::DEF_TABLE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  hwas_pkg::cmd_t                      cmd,
  input  logic                                cfg_wr_en,
  input  logic        [hwas_pkg::STEP_W-1:0]  cfg_wr_data,
  input  logic        [hwas_pkg::TADDR_W-1:0] in_table_address,
  input  logic signed [hwas_pkg::SAMP_W-1:0]  in_table_value,
  input  logic        [hwas_pkg::HNUM_W-1:0]  in_harmonic_number,
  input  logic signed [hwas_pkg::GAIN_W-1:0]  in_gain_value,
  output logic signed [hwas_pkg::SAMP_W-1:0]  out_sample_out
);

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int PW    = AW + hwas_pkg::FRAC_W;
  localparam int RW    = PW + 7;
  localparam int CH    = $clog2(HARMONICS);
  localparam int ACC_W = 32 + CH;
  localparam int DVD_W = hwas_pkg::QUO_W + CH;
  localparam int RSH   = DVD_W + CH;
  localparam int EXT_W = (AW > hwas_pkg::TADDR_W) ? AW : hwas_pkg::TADDR_W;
  localparam logic [PW:0]   PH_MOD  = (PW + 1)'(TABLE_DEPTH) << hwas_pkg::FRAC_W;
  localparam logic [RW-1:0] RED_MOD = RW'(TABLE_DEPTH) << hwas_pkg::FRAC_W;
  // Rounded-up reciprocal of the count, exact for every biased sum
  localparam logic [DVD_W:0] RECIP =
    (DVD_W + 1)'(((64'd1 << RSH) + 64'(HARMONICS) - 64'd1) / 64'(HARMONICS));

  // Reduce a raw step modulo the phase range; a step is below 64 wraps
  function automatic logic [PW-1:0] reduce_step(input logic [hwas_pkg::STEP_W-1:0] s);
    logic [RW-1:0] r;
    r = RW'(s);
    for (int j = 5; j >= 0; j--) begin
      if (r >= (RED_MOD << j)) begin
        r = r - (RED_MOD << j);
      end
    end
    return r[PW-1:0];
  endfunction

  logic        [PW-1:0]                step_r;
  logic        [PW-1:0]                inc_r;
  logic        [PW-1:0]                phase_ring_r [HARMONICS];
  logic signed [hwas_pkg::GAIN_W-1:0]  gain_ring_r  [HARMONICS];
  logic signed [hwas_pkg::SAMP_W-1:0]  wave_mem     [TABLE_DEPTH];
  logic signed [hwas_pkg::SAMP_W-1:0]  rd0_r, rd1_r;
  logic signed [33:0]                  prod_r;
  logic signed [31:0]                  gprod_r;
  logic signed [ACC_W-1:0]             acc_r;
  logic        [DVD_W-1:0]             dvd_r;
  logic        [hwas_pkg::QUO_W-1:0]   quo_r;
  logic signed [hwas_pkg::SAMP_W-1:0]  out_r;

  logic [EXT_W-1:0]                    addr_ext;
  logic                                addr_ok;
  logic [AW-1:0]                       i0, i1;
  logic signed [16:0]                  diff;
  logic signed [16:0]                  frac;
  logic signed [17:0]                  isum;
  logic signed [hwas_pkg::SAMP_W-1:0]  interp;
  logic [PW:0]                         ph_sum, inc_sum;
  logic [PW-1:0]                       ph_nxt, inc_nxt;
  logic [DVD_W:0]                      biased;
  logic [2*DVD_W:0]                    qprod;

  // Table write address check
  assign addr_ext = EXT_W'(in_table_address);
  assign addr_ok  = (32'(in_table_address) < TABLE_DEPTH);

  // Entry pair around the head phase, wrapping at the table end
  assign i0 = phase_ring_r[0][PW-1:hwas_pkg::FRAC_W];
  assign i1 = (i0 == AW'(TABLE_DEPTH - 1)) ? '0 : i0 + AW'(1);

  // Linear interpolation, floor of the fractional product
  assign diff   = 17'(rd1_r) - 17'(rd0_r);
  assign frac   = {1'b0, phase_ring_r[0][hwas_pkg::FRAC_W-1:0]};
  assign isum   = 18'(rd0_r) + 18'(prod_r >>> hwas_pkg::FRAC_W);
  assign interp = isum[hwas_pkg::SAMP_W-1:0];

  // Phase and per-harmonic increment, both kept below the phase range
  assign ph_sum  = {1'b0, phase_ring_r[0]} + {1'b0, inc_r};
  assign ph_nxt  = (ph_sum >= PH_MOD) ? PW'(ph_sum - PH_MOD) : ph_sum[PW-1:0];
  assign inc_sum = {1'b0, inc_r} + {1'b0, step_r};
  assign inc_nxt = (inc_sum >= PH_MOD) ? PW'(inc_sum - PH_MOD) : inc_sum[PW-1:0];

  // Drop the Q1.15 scale, then bias so the divide by the count is unsigned
  assign biased = {acc_r[ACC_W-1], acc_r[ACC_W-1:15]} + (DVD_W + 1)'(HARMONICS << 15);

  // Divide by the harmonic count: multiply by the reciprocal, keep the top
  assign qprod = (2*DVD_W + 1)'(dvd_r) * (2*DVD_W + 1)'(RECIP);

  // Configuration and harmonic state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      for (int j = 0; j < HARMONICS; j++) begin
        phase_ring_r[j] <= '0;
        gain_ring_r[j]  <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        step_r <= reduce_step(cfg_wr_data);
      end
      if (cmd.wr_gain) begin
        for (int j = 0; j < HARMONICS; j++) begin
          if (32'(in_harmonic_number) == j) begin
            gain_ring_r[j] <= in_gain_value;
          end
        end
      end else if (cmd.acc) begin
        // rotate: the updated head goes to the tail
        for (int j = 0; j < HARMONICS - 1; j++) begin
          phase_ring_r[j] <= phase_ring_r[j+1];
          gain_ring_r[j]  <= gain_ring_r[j+1];
        end
        phase_ring_r[HARMONICS-1] <= ph_nxt;
        gain_ring_r[HARMONICS-1]  <= gain_ring_r[0];
      end
    end
  end

  // Wave table: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.wr_table && addr_ok) begin
      wave_mem[addr_ext[AW-1:0]] <= in_table_value;
    end
    if (cmd.read) begin
      rd0_r <= wave_mem[i0];
      rd1_r <= wave_mem[i1];
    end
  end

  // Multipliers, accumulator, divider and result
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      inc_r <= step_r;
      acc_r <= '0;
    end
    if (cmd.mul) begin
      prod_r <= diff * frac;
    end
    if (cmd.gain) begin
      gprod_r <= interp * gain_ring_r[0];
    end
    if (cmd.acc) begin
      acc_r <= acc_r + ACC_W'(gprod_r);
      inc_r <= inc_nxt;
    end
    if (cmd.div_init) begin
      dvd_r <= biased[DVD_W-1:0];
    end
    if (cmd.div_step) begin
      quo_r <= qprod[RSH +: hwas_pkg::QUO_W];
    end
    // unbias and saturate the quotient
    if (cmd.load_out) begin
      out_r <= quo_r[hwas_pkg::QUO_W-1] ? 16'sh7FFF : {~quo_r[15], quo_r[14:0]};
    end
  end

  assign out_sample_out = out_r;

endmodule

### rtl/core/harmonic_wavetable_additive_synth_core.sv
// ----------------------------------------------------------------------------
// harmonic_wavetable_additive_synth_core
// Additive wavetable synthesizer: table and gain writes, and one averaged,
// interpolated, gained sample per sample request.
//
//   channel  direction  handshake         payload
//   in_      sink       in_valid/stall    func, table_address, table_value,
//                                         harmonic_number, gain_value
//   out_     source     out_valid/stall   sample_out
//   cfg_     sink       cfg_wr_en         cfg_wr_data (phase step)
//
// A table or gain write is handled in the idle state. A sample request steps
// through the cycle that takes it, then per harmonic the shared table read,
// interpolation multiplier, gain multiplier and accumulate, then the bias
// of the sum, the divide by the count through a reciprocal multiply and the
// load of the result register.
// Reset is synchronous and clears phases, gains and the phase step; the wave
// table holds no reset value. A finished sample waits in the result register
// while new requests are taken; a new sample waits only if that register is
// still stalled.
// ----------------------------------------------------------------------------
module harmonic_wavetable_additive_synth_core #(
  parameter int HARMONICS   = hwas_pkg::DEF_HARMONICS,
  parameter int TABLE_DEPTH = hwas_pkg::DEF_TABLE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic        [hwas_pkg::STEP_W-1:0]  cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic        [hwas_pkg::FUNC_W-1:0]  in_func,
  input  logic        [hwas_pkg::TADDR_W-1:0] in_table_address,
  input  logic signed [hwas_pkg::SAMP_W-1:0]  in_table_value,
  input  logic        [hwas_pkg::HNUM_W-1:0]  in_harmonic_number,
  input  logic signed [hwas_pkg::GAIN_W-1:0]  in_gain_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [hwas_pkg::SAMP_W-1:0]  out_sample_out
);

  hwas_pkg::cmd_t cmd;

  // Sequencer
  hwas_ctrl #(
    .HARMONICS (HARMONICS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_func   (in_func),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Datapath
  hwas_dp #(
    .HARMONICS   (HARMONICS),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_table_address   (in_table_address),
    .in_table_value     (in_table_value),
    .in_harmonic_number (in_harmonic_number),
    .in_gain_value      (in_gain_value),
    .out_sample_out     (out_sample_out)
  );

endmodule
